// ===== design/brb_pkg.sv =====
`timescale 1ns / 1ps

package brb_pkg;

   // field widths of the ports
   localparam int CW = 11;   // counts, levels, capacity, ring positions
   localparam int DW = 8;    // one stored byte
   localparam int FW = 3;    // function code

   // saturation point of the accepted-in-burst counter
   localparam logic [CW-1:0] CntMax = 11'd2047;

   // function codes; anything above FN_QUERY acts as a level query
   localparam logic [FW-1:0] FN_PUSH  = 3'd0;
   localparam logic [FW-1:0] FN_READ  = 3'd1;
   localparam logic [FW-1:0] FN_PEEK  = 3'd2;
   localparam logic [FW-1:0] FN_SKIP  = 3'd3;
   localparam logic [FW-1:0] FN_FLUSH = 3'd4;
   localparam logic [FW-1:0] FN_QUERY = 3'd5;

   // one result word
   typedef struct packed {
      logic [DW-1:0] data_out;
      logic          has_data;
      logic [CW-1:0] count_done;
      logic [CW-1:0] level;
      logic          last;
   } rsp_type;

   // storage access from the sequencer, ring positions before address mapping
   typedef struct packed {
      logic          wr_en;
      logic [CW-1:0] wr_idx;
      logic [DW-1:0] wr_data;
      logic          rd_en;
      logic [CW-1:0] rd_idx;
   } mem_req_type;

   // ring advance: idx < cap and n <= cap, so one conditional subtract wraps
   function automatic logic [CW-1:0] wrap_add(input logic [CW-1:0] idx,
                                              input logic [CW-1:0] n,
                                              input logic [CW-1:0] cap);
      logic [CW:0] sum;
      sum = {1'b0, idx} + {1'b0, n};
      if (sum >= {1'b0, cap}) begin
         sum = sum - {1'b0, cap};
      end
      return sum[CW-1:0];
   endfunction

endpackage

// ===== design/brb_if.sv =====
`timescale 1ns / 1ps

// request channel
interface brb_req_if;
   import brb_pkg::*;
   logic          valid;
   logic          ready;
   logic [FW-1:0] func;
   logic [DW-1:0] data_in;
   logic          last_in;
   logic [CW-1:0] amount;

   modport source (output valid, func, data_in, last_in, amount, input ready);
   modport sink   (input valid, func, data_in, last_in, amount, output ready);
endinterface

// result channel
interface brb_rsp_if;
   import brb_pkg::*;
   logic          valid;
   logic          ready;
   logic [DW-1:0] data_out;
   logic          has_data;
   logic [CW-1:0] count_done;
   logic [CW-1:0] level;
   logic          last;

   modport source (output valid, data_out, has_data, count_done, level, last,
                   input ready);
   modport sink   (input valid, data_out, has_data, count_done, level, last,
                   output ready);
endinterface

// capacity register write channel
interface brb_csr_if;
   import brb_pkg::*;
   logic          valid;
   logic          ready;
   logic [CW-1:0] data;

   modport source (output valid, data, input ready);
   modport sink   (input valid, data, output ready);
endinterface

// ===== design/byte_ring_buffer_with_peek.sv =====
`timescale 1ns / 1ps
// push, skip, flush and query: result passes the staging register, then the result queue
// read and peek of n bytes: one byte per cycle while the result queue has room, paced by
// the single storage read port; new requests wait until the burst ends
// reset: indices, fill level and burst count go to zero, capacity to 1024;
// storage contents are not cleared and need no clearing pass
module byte_ring_buffer_with_peek #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input logic       clock,
   input logic       reset,
   brb_req_if.sink   req_bus,
   brb_rsp_if.source rsp_bus,
   brb_csr_if.sink   csr_bus
);
   import brb_pkg::*;

   localparam int AddrW = $clog2(DEPTH);

   mem_req_type   mem_req;
   logic          stg_valid;
   logic          stg_byte;
   rsp_type       stg_res;
   logic [DW-1:0] rd_data;
   rsp_type       push_word;
   logic [1:0]    q_count;
   logic [2:0]    occ;
   logic          pop;
   logic          room;

   // room for one more word: queued plus staged, less the one leaving
   assign pop  = rsp_bus.valid && rsp_bus.ready;
   assign occ  = {1'b0, q_count} + {2'b00, stg_valid};
   assign room = (occ < 3'd2) || ((occ == 3'd2) && pop);

   brb_ctrl #(
      .DEPTH     (DEPTH),
      .MAX_BURST (MAX_BURST)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req       (req_bus),
      .csr       (csr_bus),
      .room      (room),
      .mem_req   (mem_req),
      .stg_valid (stg_valid),
      .stg_byte  (stg_byte),
      .stg_res   (stg_res)
   );

   brb_ram #(
      .WIDTH (DW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (AddrW'(mem_req.wr_idx)),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (AddrW'(mem_req.rd_idx)),
      .rd_data (rd_data)
   );

   // merge read data into the staged result
   always_comb begin
      push_word = stg_res;
      if (stg_byte) begin
         push_word.data_out = rd_data;
      end
   end

   brb_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (stg_valid),
      .push_word (push_word),
      .count     (q_count),
      .rsp       (rsp_bus)
   );

endmodule

// ===== design/brb_ram.sv =====
`timescale 1ns / 1ps

module brb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port; read data holds between reads
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/brb_rsp_queue.sv =====
`timescale 1ns / 1ps

module brb_rsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  brb_pkg::rsp_type  push_word,
   output logic [1:0]        count,
   brb_rsp_if.source         rsp
);
   import brb_pkg::*;

   rsp_type    slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;
   rsp_type    head;

   assign pop  = rsp.valid && rsp.ready;
   assign head = slot_ff[rd_ptr_ff];

   // output side
   assign rsp.valid      = (count_ff != 2'd0);
   assign rsp.data_out   = head.data_out;
   assign rsp.has_data   = head.has_data;
   assign rsp.count_done = head.count_done;
   assign rsp.level      = head.level;
   assign rsp.last       = head.last;
   assign count          = count_ff;

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // payload slots
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_word;
      end
   end

endmodule

// ===== design/brb_ctrl.sv =====
`timescale 1ns / 1ps

module brb_ctrl #(
   parameter int DEPTH     = 1024,
   parameter int MAX_BURST = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   brb_req_if.sink              req,
   brb_csr_if.sink              csr,
   input  logic                 room,
   output brb_pkg::mem_req_type mem_req,
   output logic                 stg_valid,
   output logic                 stg_byte,
   output brb_pkg::rsp_type     stg_res
);
   import brb_pkg::*;

   localparam int CapMax = (DEPTH > 2047) ? 2047 : DEPTH;
   localparam int RemW   = $clog2(MAX_BURST + 1);

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_BURST = 2'b10
   } state_type;

   state_type     state_ff, state_in;
   logic [CW-1:0] cap_ff, cap_in;
   logic [CW-1:0] rd_idx_ff, rd_idx_in;
   logic [CW-1:0] wr_idx_ff, wr_idx_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic [CW-1:0] bacc_ff, bacc_in;
   logic [CW-1:0] pos_ff, pos_in;
   logic [CW-1:0] lvl_ff, lvl_in;
   logic [RemW-1:0] rem_ff, rem_in;
   logic [RemW-1:0] n_ff, n_in;
   logic          consume_ff, consume_in;
   logic          stg_valid_ff, stg_valid_in;
   logic          stg_byte_ff, stg_byte_in;
   rsp_type       stg_res_ff, stg_res_in;

   logic          req_accept;
   logic          csr_accept;
   logic [CW-1:0] cap_eff;
   logic          push_ok;
   logic [CW-1:0] bacc_next;
   logic [CW-1:0] n_lvl;
   logic [CW-1:0] n_burst;
   logic [CW-1:0] next_pos;
   logic [CW-1:0] next_lvl;

   // a pending capacity write holds off the request side
   assign req.ready  = (state_ff == ST_IDLE) && room && !csr.valid;
   assign csr.ready  = (state_ff == ST_IDLE);
   assign req_accept = req.valid && req.ready;
   assign csr_accept = csr.valid && csr.ready;

   assign stg_valid = stg_valid_ff;
   assign stg_byte  = stg_byte_ff;
   assign stg_res   = stg_res_ff;

   // capacity in force: zero acts as one, large values stop at the storage size, at most 2047
   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CW'(1);
      end else if (cap_ff > CW'(CapMax)) begin
         cap_eff = CW'(CapMax);
      end else begin
         cap_eff = cap_ff;
      end
   end

   // shared request arithmetic
   always_comb begin
      push_ok   = (fill_ff < cap_eff);
      bacc_next = bacc_ff;
      if (push_ok && (bacc_ff < CntMax)) begin
         bacc_next = bacc_ff + CW'(1);
      end
      n_lvl   = (req.amount < fill_ff) ? req.amount : fill_ff;
      n_burst = (n_lvl > CW'(MAX_BURST)) ? CW'(MAX_BURST) : n_lvl;
      next_pos = wrap_add(pos_ff, CW'(1), cap_eff);
      next_lvl = consume_ff ? (lvl_ff - CW'(1)) : lvl_ff;
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cap_in       = cap_ff;
      rd_idx_in    = rd_idx_ff;
      wr_idx_in    = wr_idx_ff;
      fill_in      = fill_ff;
      bacc_in      = bacc_ff;
      pos_in       = pos_ff;
      lvl_in       = lvl_ff;
      rem_in       = rem_ff;
      n_in         = n_ff;
      consume_in   = consume_ff;
      stg_valid_in = 1'b0;
      stg_byte_in  = 1'b0;
      stg_res_in   = '0;
      mem_req      = '0;

      if (csr_accept) begin
         // capacity write empties the ring, burst count kept
         cap_in    = csr.data;
         rd_idx_in = '0;
         wr_idx_in = '0;
         fill_in   = '0;
      end else if (req_accept) begin
         case (req.func)
            FN_PUSH: begin
               if (push_ok) begin
                  mem_req.wr_en   = 1'b1;
                  mem_req.wr_idx  = wr_idx_ff;
                  mem_req.wr_data = req.data_in;
                  wr_idx_in       = wrap_add(wr_idx_ff, CW'(1), cap_eff);
                  fill_in         = fill_ff + CW'(1);
               end
               bacc_in               = req.last_in ? '0 : bacc_next;
               stg_valid_in          = 1'b1;
               stg_res_in.has_data   = push_ok;
               stg_res_in.count_done = req.last_in ? bacc_next : '0;
               stg_res_in.level      = fill_in;
               stg_res_in.last       = 1'b1;
            end
            FN_READ, FN_PEEK: begin
               if (n_burst == '0) begin
                  stg_valid_in     = 1'b1;
                  stg_res_in.level = fill_ff;
                  stg_res_in.last  = 1'b1;
               end else begin
                  state_in   = ST_BURST;
                  pos_in     = rd_idx_ff;
                  lvl_in     = fill_ff;
                  rem_in     = n_burst[RemW-1:0];
                  n_in       = n_burst[RemW-1:0];
                  consume_in = (req.func == FN_READ);
               end
            end
            FN_SKIP: begin
               rd_idx_in             = wrap_add(rd_idx_ff, n_lvl, cap_eff);
               fill_in               = fill_ff - n_lvl;
               stg_valid_in          = 1'b1;
               stg_res_in.count_done = n_lvl;
               stg_res_in.level      = fill_in;
               stg_res_in.last       = 1'b1;
            end
            FN_FLUSH: begin
               wr_idx_in             = rd_idx_ff;
               fill_in               = '0;
               stg_valid_in          = 1'b1;
               stg_res_in.count_done = fill_ff;
               stg_res_in.last       = 1'b1;
            end
            default: begin
               stg_valid_in     = 1'b1;
               stg_res_in.level = fill_ff;
               stg_res_in.last  = 1'b1;
            end
         endcase
      end else if ((state_ff == ST_BURST) && room) begin
         // one byte read per cycle while the result queue has room, result fields travel alongside
         mem_req.rd_en       = 1'b1;
         mem_req.rd_idx      = pos_ff;
         pos_in              = next_pos;
         lvl_in              = next_lvl;
         rem_in              = rem_ff - RemW'(1);
         stg_valid_in        = 1'b1;
         stg_byte_in         = 1'b1;
         stg_res_in.has_data = 1'b1;
         stg_res_in.level    = next_lvl;
         if (rem_ff == RemW'(1)) begin
            state_in              = ST_IDLE;
            stg_res_in.count_done = CW'(n_ff);
            stg_res_in.last       = 1'b1;
            if (consume_ff) begin
               rd_idx_in = next_pos;
               fill_in   = next_lvl;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= 11'd1024;
         rd_idx_ff    <= '0;
         wr_idx_ff    <= '0;
         fill_ff      <= '0;
         bacc_ff      <= '0;
         rem_ff       <= '0;
         stg_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_ff       <= cap_in;
         rd_idx_ff    <= rd_idx_in;
         wr_idx_ff    <= wr_idx_in;
         fill_ff      <= fill_in;
         bacc_ff      <= bacc_in;
         rem_ff       <= rem_in;
         stg_valid_ff <= stg_valid_in;
      end
   end

   // burst context and staged result
   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      lvl_ff      <= lvl_in;
      n_ff        <= n_in;
      consume_ff  <= consume_in;
      stg_byte_ff <= stg_byte_in;
      stg_res_ff  <= stg_res_in;
   end

endmodule
